// ===== rtl/core/credit_fair_dram_cmd_scheduler_top_defines.svh =====
// Assertion macros shared by the scheduler's checker.
`ifndef CREDIT_FAIR_DRAM_CMD_SCHEDULER_TOP_DEFINES_SVH
`define CREDIT_FAIR_DRAM_CMD_SCHEDULER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define CFDCS_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cfdcs check failed");

// Next-cycle implication, sampled on clock, off while reset is high.
`define CFDCS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cfdcs check failed");

`endif

// ===== rtl/core/cfdcs_pkg.sv =====
// Types and constants of the credit-fair DRAM command scheduler.
package cfdcs_pkg;

   localparam int CRED_W      = 11;
   localparam int EFF_W       = 12;
   localparam int CYCLE_W     = 48;
   localparam int QLEN_W      = 7;
   localparam int CHAN_IN_W   = 2;
   localparam int THREAD_IN_W = 7;
   localparam int INDEX_W     = 6;
   localparam int DCNT_W      = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;

   localparam logic [CRED_W-1:0] RESET_CREDIT      = 11'd1024;
   localparam logic [QLEN_W-1:0] RESET_HIGH_WM     = 7'd40;
   localparam logic [QLEN_W-1:0] RESET_LOW_WM      = 7'd20;
   localparam logic [DCNT_W-1:0] RESET_MIN_DRAIN   = 8'd1;
   localparam logic [DCNT_W-1:0] DCNT_MAX          = 8'd255;

   typedef enum logic [1:0] {
      MODE_BEGIN = 2'd0,
      MODE_READ  = 2'd1,
      MODE_WRITE = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HIGH_WM    = 2'd0,
      CSR_LOW_WM     = 2'd1,
      CSR_MIN_DRAIN  = 2'd2,
      CSR_CREDIT_CAP = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_BEGIN,
      ST_SWEEP,
      ST_ENTRY
   } state_type;

   typedef struct packed {
      logic [QLEN_W-1:0] high_wm;
      logic [QLEN_W-1:0] low_wm;
      logic [DCNT_W-1:0] min_drain;
      logic [CRED_W-1:0] credit_cap;
   } csr_type;

   typedef struct packed {
      logic              update;
      logic              count;
      logic [QLEN_W-1:0] rq;
      logic [QLEN_W-1:0] wq;
   } drain_cmd_type;

endpackage

// ===== rtl/core/cfdcs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cfdcs_ram #(
   parameter int WIDTH = 11,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/cfdcs_credit_alu.sv =====
// Shared credit adder and comparator: credit refresh and effective-credit ranking.
module cfdcs_credit_alu import cfdcs_pkg::*; (
   input  logic [CRED_W-1:0] credit,
   input  logic [CRED_W-1:0] addend,
   input  logic [EFF_W-1:0]  limit,
   output logic [EFF_W-1:0]  sum,
   output logic              gt
);

   always_comb begin
      sum = {1'b0, credit} + {1'b0, addend};
      gt  = sum > limit;
   end

endmodule

// ===== rtl/core/cfdcs_drain.sv =====
// Per-channel write-drain mode state and its watermark rules.
module cfdcs_drain import cfdcs_pkg::*; #(
   parameter int CHANNELS = 4
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  csr_type                                       csr,
   input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] ch,
   input  drain_cmd_type                                 cmd,
   output logic                                          flag
);

   logic              flag_ff  [CHANNELS];
   logic              flag_in  [CHANNELS];
   logic              empty_ff [CHANNELS];
   logic              empty_in [CHANNELS];
   logic [DCNT_W-1:0] count_ff [CHANNELS];
   logic [DCNT_W-1:0] count_in [CHANNELS];

   logic              f;
   logic              e;
   logic [DCNT_W-1:0] n;

   always_comb begin
      flag_in  = flag_ff;
      empty_in = empty_ff;
      count_in = count_ff;
      f = flag_ff[ch];
      e = empty_ff[ch];
      n = count_ff[ch];
      if (cmd.update) begin
         if (cmd.wq > csr.high_wm && !f) begin
            f = 1'b1;
            n = '0;
         end
         // drain into an empty read queue
         if (cmd.rq == '0 && cmd.wq != '0 && !f) begin
            f = 1'b1;
            n = '0;
            e = 1'b1;
         end
         if (f && cmd.wq <= csr.low_wm && !e) begin
            f = 1'b0;
         end
         if (f && cmd.rq != '0 && e && n > csr.min_drain) begin
            f = 1'b0;
            e = 1'b0;
         end
         if (cmd.wq == '0) begin
            f = 1'b0;
         end
      end else if (cmd.count) begin
         if (n != DCNT_MAX) begin
            n = n + 1'b1;
         end
      end
      flag_in[ch]  = f;
      empty_in[ch] = e;
      count_in[ch] = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            flag_ff[i]  <= 1'b0;
            empty_ff[i] <= 1'b0;
            count_ff[i] <= '0;
         end
      end else begin
         flag_ff  <= flag_in;
         empty_ff <= empty_in;
         count_ff <= count_in;
      end
   end

   assign flag = flag_ff[ch];

endmodule

// ===== rtl/core/credit_fair_dram_cmd_scheduler_top.sv =====
// Top level of the credit-fair DRAM command scheduler.
// A request is taken when start is high and busy is low. For a queue entry, the accept
// cycle reads the thread's credit from RAM and the ST_ENTRY state ranks it. A begin pass
// runs the accept cycle, ST_BEGIN for elapsed time and the drain rules, then one RAM
// read/write sweep (ST_SWEEP) that passes every thread of the channel through the shared
// add-and-compare unit. A result appears on rsp_valid for exactly one cycle, the cycle
// after the request's last cycle, and must be taken then: the receiver cannot stall.
// After reset the credit RAM is cleared, one entry a cycle, over all CHANNELS *
// 2**ceil(log2(THREADS)) entries (512 by default) with busy high; csr writes are taken
// at any time (csr_ready is always high) but belong in idle time.
module credit_fair_dram_cmd_scheduler_top import cfdcs_pkg::*; #(
   parameter int THREADS  = 128,
   parameter int CHANNELS = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             req_mode,
   input  logic [CHAN_IN_W-1:0]   req_channel,
   input  logic [CYCLE_W-1:0]     req_cycle_now,
   input  logic [QLEN_W-1:0]      req_read_queue_len,
   input  logic [QLEN_W-1:0]      req_write_queue_len,
   input  logic                   req_entry_issuable,
   input  logic                   req_entry_row_hit,
   input  logic [THREAD_IN_W-1:0] req_entry_thread,
   input  logic [INDEX_W-1:0]     req_entry_index,
   input  logic                   req_last_item,
   output logic                   rsp_valid,
   output logic                   rsp_grant_valid,
   output logic                   rsp_grant_is_write,
   output logic [INDEX_W-1:0]     rsp_grant_index,
   output logic                   rsp_drain_active,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int TW        = $clog2(THREADS);
   localparam int CW        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int RAM_DEPTH = CHANNELS << TW;
   localparam int RAM_AW    = $clog2(RAM_DEPTH);
   localparam int SWP_W     = $clog2(THREADS + 1);

   function automatic logic [CW-1:0] chan_mod(input logic [CHAN_IN_W-1:0] v);
      int w;
      w = int'(v);
      for (int k = CHAN_IN_W - 1; k >= 0; k--) begin
         if (w >= (CHANNELS << k)) begin
            w = w - (CHANNELS << k);
         end
      end
      return CW'(w);
   endfunction

   function automatic logic [TW-1:0] thread_mod(input logic [THREAD_IN_W-1:0] v);
      int w;
      w = int'(v);
      for (int k = THREAD_IN_W - 1; k >= 0; k--) begin
         if (w >= (THREADS << k)) begin
            w = w - (THREADS << k);
         end
      end
      return TW'(w);
   endfunction

   function automatic logic [RAM_AW-1:0] ram_addr(input logic [CW-1:0] ch,
                                                  input logic [TW-1:0] t);
      logic [CW+TW-1:0] a;
      a = {ch, t};
      return a[RAM_AW-1:0];
   endfunction

   // control state
   state_type          state_ff, state_in;
   logic [RAM_AW-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [CW-1:0]      pass_channel_ff, pass_channel_in;
   logic [SWP_W-1:0]   swp_cnt_ff, swp_cnt_in;
   logic               wr_pend_ff, wr_pend_in;
   logic               best_valid_ff, best_valid_in;
   logic               best_write_ff, best_write_in;
   logic               best_hit_ff, best_hit_in;
   logic [EFF_W-1:0]   best_eff_ff, best_eff_in;
   logic [CYCLE_W-1:0] last_cycle_ff [CHANNELS];
   logic [CYCLE_W-1:0] last_cycle_in [CHANNELS];
   csr_type            csr_ff, csr_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // payload
   mode_type           ent_mode_ff, ent_mode_in;
   logic               ent_issuable_ff, ent_issuable_in;
   logic               ent_hit_ff, ent_hit_in;
   logic [TW-1:0]      ent_thread_ff, ent_thread_in;
   logic [INDEX_W-1:0] ent_index_ff, ent_index_in;
   logic               last_ff, last_in;
   logic [CYCLE_W-1:0] now_ff, now_in;
   logic [QLEN_W-1:0]  rq_ff, rq_in;
   logic [QLEN_W-1:0]  wq_ff, wq_in;
   logic [CRED_W-1:0]  elapsed_ff, elapsed_in;
   logic [TW-1:0]      wr_t_ff, wr_t_in;
   logic [INDEX_W-1:0] best_index_ff, best_index_in;
   logic [TW-1:0]      best_thread_ff, best_thread_in;
   logic [CRED_W-1:0]  best_raw_ff, best_raw_in;
   logic               rsp_grant_valid_ff, rsp_grant_valid_in;
   logic               rsp_grant_is_write_ff, rsp_grant_is_write_in;
   logic [INDEX_W-1:0] rsp_grant_index_ff, rsp_grant_index_in;
   logic               rsp_drain_active_ff, rsp_drain_active_in;

   // datapath nets
   logic               accept;
   logic               rd_issue;
   logic               ram_we;
   logic [RAM_AW-1:0]  ram_waddr;
   logic [CRED_W-1:0]  ram_wdata;
   logic [RAM_AW-1:0]  ram_raddr;
   logic [CRED_W-1:0]  ram_rdata;
   logic [CRED_W-1:0]  alu_addend;
   logic [EFF_W-1:0]   alu_limit;
   logic [EFF_W-1:0]   alu_sum;
   logic               alu_gt;
   drain_cmd_type      drain_cmd;
   logic               drain_flag;
   logic [CYCLE_W-1:0] diff;
   logic               cand_ok;
   logic               take;
   logic               nb_valid;
   logic               nb_write;
   logic               nb_hit;
   logic [INDEX_W-1:0] nb_index;
   logic [TW-1:0]      nb_thread;
   logic [CRED_W-1:0]  nb_raw;

   cfdcs_ram #(
      .WIDTH (CRED_W),
      .DEPTH (RAM_DEPTH)
   ) u_credit_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   cfdcs_credit_alu u_alu (
      .credit (ram_rdata),
      .addend (alu_addend),
      .limit  (alu_limit),
      .sum    (alu_sum),
      .gt     (alu_gt)
   );

   cfdcs_drain #(
      .CHANNELS (CHANNELS)
   ) u_drain (
      .clock (clock),
      .reset (reset),
      .csr   (csr_ff),
      .ch    (pass_channel_ff),
      .cmd   (drain_cmd),
      .flag  (drain_flag)
   );

   assign accept   = start && (state_ff == ST_IDLE);
   assign rd_issue = swp_cnt_ff < SWP_W'(THREADS);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == RAM_AW'(RAM_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = (mode_type'(req_mode) == MODE_BEGIN) ? ST_BEGIN : ST_ENTRY;
            end
         end
         ST_BEGIN: state_in = ST_SWEEP;
         ST_SWEEP: begin
            if (!rd_issue) begin
               state_in = ST_IDLE;
            end
         end
         ST_ENTRY: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      clr_cnt_in            = clr_cnt_ff;
      pass_channel_in       = pass_channel_ff;
      swp_cnt_in            = swp_cnt_ff;
      wr_pend_in            = 1'b0;
      best_valid_in         = best_valid_ff;
      best_write_in         = best_write_ff;
      best_hit_in           = best_hit_ff;
      best_eff_in           = best_eff_ff;
      last_cycle_in         = last_cycle_ff;
      csr_in                = csr_ff;
      rsp_valid_in          = 1'b0;
      ent_mode_in           = ent_mode_ff;
      ent_issuable_in       = ent_issuable_ff;
      ent_hit_in            = ent_hit_ff;
      ent_thread_in         = ent_thread_ff;
      ent_index_in          = ent_index_ff;
      last_in               = last_ff;
      now_in                = now_ff;
      rq_in                 = rq_ff;
      wq_in                 = wq_ff;
      elapsed_in            = elapsed_ff;
      wr_t_in               = wr_t_ff;
      best_index_in         = best_index_ff;
      best_thread_in        = best_thread_ff;
      best_raw_in           = best_raw_ff;
      rsp_grant_valid_in    = rsp_grant_valid_ff;
      rsp_grant_is_write_in = rsp_grant_is_write_ff;
      rsp_grant_index_in    = rsp_grant_index_ff;
      rsp_drain_active_in   = rsp_drain_active_ff;
      ram_we                = 1'b0;
      ram_waddr             = '0;
      ram_wdata             = '0;
      ram_raddr             = ram_addr(pass_channel_ff, thread_mod(req_entry_thread));
      alu_addend            = ent_hit_ff ? (ram_rdata >> 1) : '0;
      alu_limit             = best_eff_ff;
      drain_cmd             = '{update: 1'b0, count: 1'b0, rq: rq_ff, wq: wq_ff};
      diff                  = now_ff - last_cycle_ff[pass_channel_ff];
      cand_ok               = ent_issuable_ff &&
                              ((drain_flag && ent_mode_ff == MODE_WRITE) ||
                               (!drain_flag && ent_mode_ff == MODE_READ));
      take                  = drain_flag ? (!best_valid_ff || (!best_hit_ff && ent_hit_ff))
                                         : (!best_valid_ff || alu_gt);
      nb_valid              = best_valid_ff;
      nb_write              = best_write_ff;
      nb_hit                = best_hit_ff;
      nb_index              = best_index_ff;
      nb_thread             = best_thread_ff;
      nb_raw                = best_raw_ff;

      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_HIGH_WM:    csr_in.high_wm    = csr_wdata[QLEN_W-1:0];
            CSR_LOW_WM:     csr_in.low_wm     = csr_wdata[QLEN_W-1:0];
            CSR_MIN_DRAIN:  csr_in.min_drain  = csr_wdata[DCNT_W-1:0];
            CSR_CREDIT_CAP: csr_in.credit_cap = csr_wdata[CRED_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            ram_we     = 1'b1;
            ram_waddr  = clr_cnt_ff;
            ram_wdata  = RESET_CREDIT;
            clr_cnt_in = clr_cnt_ff + 1'b1;
         end
         ST_IDLE: begin
            if (accept) begin
               ent_mode_in     = mode_type'(req_mode);
               ent_issuable_in = req_entry_issuable;
               ent_hit_in      = req_entry_row_hit;
               ent_thread_in   = thread_mod(req_entry_thread);
               ent_index_in    = req_entry_index;
               last_in         = req_last_item;
               now_in          = req_cycle_now;
               rq_in           = req_read_queue_len;
               wq_in           = req_write_queue_len;
               if (mode_type'(req_mode) == MODE_BEGIN) begin
                  pass_channel_in = chan_mod(req_channel);
                  best_valid_in   = 1'b0;
                  best_write_in   = 1'b0;
                  best_hit_in     = 1'b0;
                  best_eff_in     = '0;
               end
            end
         end
         ST_BEGIN: begin
            // clamp elapsed time: anything at or past the ceiling saturates
            elapsed_in = (diff[CYCLE_W-1:CRED_W] != '0) ? '1 : diff[CRED_W-1:0];
            last_cycle_in[pass_channel_ff] = now_ff;
            drain_cmd.update = 1'b1;
            swp_cnt_in = '0;
         end
         ST_SWEEP: begin
            ram_raddr  = ram_addr(pass_channel_ff, swp_cnt_ff[TW-1:0]);
            alu_addend = elapsed_ff;
            alu_limit  = {1'b0, csr_ff.credit_cap};
            wr_pend_in = rd_issue;
            wr_t_in    = swp_cnt_ff[TW-1:0];
            if (rd_issue) begin
               swp_cnt_in = swp_cnt_ff + 1'b1;
            end
            // write back the credit read in the previous cycle
            if (wr_pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = ram_addr(pass_channel_ff, wr_t_ff);
               ram_wdata = alu_gt ? csr_ff.credit_cap : alu_sum[CRED_W-1:0];
            end
            if (!rd_issue && last_ff) begin
               rsp_valid_in          = 1'b1;
               rsp_grant_valid_in    = 1'b0;
               rsp_grant_is_write_in = 1'b0;
               rsp_grant_index_in    = '0;
               rsp_drain_active_in   = drain_flag;
            end
         end
         ST_ENTRY: begin
            if (cand_ok && take) begin
               nb_valid  = 1'b1;
               nb_write  = drain_flag;
               nb_hit    = ent_hit_ff;
               nb_index  = ent_index_ff;
               nb_thread = ent_thread_ff;
               nb_raw    = ram_rdata;
               if (!drain_flag) begin
                  best_eff_in = alu_sum;
               end
            end
            best_valid_in  = nb_valid;
            best_write_in  = nb_write;
            best_hit_in    = nb_hit;
            best_index_in  = nb_index;
            best_thread_in = nb_thread;
            best_raw_in    = nb_raw;
            if (last_ff) begin
               rsp_valid_in          = 1'b1;
               rsp_grant_valid_in    = nb_valid;
               rsp_grant_is_write_in = nb_valid && nb_write;
               rsp_grant_index_in    = nb_valid ? nb_index : '0;
               rsp_drain_active_in   = drain_flag;
               // halve the credit of a granted row-hit read
               if (nb_valid && !nb_write && nb_hit) begin
                  ram_we    = 1'b1;
                  ram_waddr = ram_addr(pass_channel_ff, nb_thread);
                  ram_wdata = nb_raw >> 1;
               end
               drain_cmd.count = nb_valid && nb_write && nb_hit;
               best_valid_in   = 1'b0;
               best_write_in   = 1'b0;
               best_hit_in     = 1'b0;
               best_eff_in     = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_cnt_ff      <= '0;
         pass_channel_ff <= '0;
         swp_cnt_ff      <= '0;
         wr_pend_ff      <= 1'b0;
         best_valid_ff   <= 1'b0;
         best_write_ff   <= 1'b0;
         best_hit_ff     <= 1'b0;
         best_eff_ff     <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            last_cycle_ff[i] <= '0;
         end
         csr_ff          <= '{high_wm: RESET_HIGH_WM, low_wm: RESET_LOW_WM,
                              min_drain: RESET_MIN_DRAIN, credit_cap: RESET_CREDIT};
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         clr_cnt_ff      <= clr_cnt_in;
         pass_channel_ff <= pass_channel_in;
         swp_cnt_ff      <= swp_cnt_in;
         wr_pend_ff      <= wr_pend_in;
         best_valid_ff   <= best_valid_in;
         best_write_ff   <= best_write_in;
         best_hit_ff     <= best_hit_in;
         best_eff_ff     <= best_eff_in;
         last_cycle_ff   <= last_cycle_in;
         csr_ff          <= csr_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_mode_ff           <= ent_mode_in;
      ent_issuable_ff       <= ent_issuable_in;
      ent_hit_ff            <= ent_hit_in;
      ent_thread_ff         <= ent_thread_in;
      ent_index_ff          <= ent_index_in;
      last_ff               <= last_in;
      now_ff                <= now_in;
      rq_ff                 <= rq_in;
      wq_ff                 <= wq_in;
      elapsed_ff            <= elapsed_in;
      wr_t_ff               <= wr_t_in;
      best_index_ff         <= best_index_in;
      best_thread_ff        <= best_thread_in;
      best_raw_ff           <= best_raw_in;
      rsp_grant_valid_ff    <= rsp_grant_valid_in;
      rsp_grant_is_write_ff <= rsp_grant_is_write_in;
      rsp_grant_index_ff    <= rsp_grant_index_in;
      rsp_drain_active_ff   <= rsp_drain_active_in;
   end

   assign busy               = (state_ff != ST_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_grant_valid    = rsp_grant_valid_ff;
   assign rsp_grant_is_write = rsp_grant_is_write_ff;
   assign rsp_grant_index    = rsp_grant_index_ff;
   assign rsp_drain_active   = rsp_drain_active_ff;

endmodule

// ===== rtl/core/cfdcs_checker.sv =====
// Port-level checker for the scheduler top, attached by bind.
`include "credit_fair_dram_cmd_scheduler_top_defines.svh"

module cfdcs_checker import cfdcs_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic               rsp_grant_valid,
   input logic               rsp_grant_is_write,
   input logic [INDEX_W-1:0] rsp_grant_index
);

   // an accepted request always occupies the sequencer
   `CFDCS_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

   // results never arrive back to back
   `CFDCS_ASSERT_NEXT(a_rsp_single, rsp_valid, !rsp_valid)

   // a result leaves the sequencer idle
   `CFDCS_ASSERT_IMPL(a_rsp_idle, rsp_valid, !busy)

   // a result without a grant carries zeroed grant fields
   `CFDCS_ASSERT_IMPL(a_no_grant_zero, rsp_valid && !rsp_grant_valid, !rsp_grant_is_write && rsp_grant_index == '0)

endmodule

bind credit_fair_dram_cmd_scheduler_top cfdcs_checker u_cfdcs_checker (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for the credit-fair DRAM command scheduler top level.
module tb import cfdcs_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_THREADS   = 128;
   localparam int NUM_CHANNELS  = 4;
   localparam int SETTLE_CYCLES = 2 * NUM_THREADS + 16;
   localparam int REPORT_LIMIT  = 10;

   typedef struct {
      mode_type                 mode;
      logic [CHAN_IN_W-1:0]     channel;
      logic [CYCLE_W-1:0]       cycle_now;
      logic [QLEN_W-1:0]        rq_len;
      logic [QLEN_W-1:0]        wq_len;
      logic                     issuable;
      logic                     row_hit;
      logic [THREAD_IN_W-1:0]   thread;
      logic [INDEX_W-1:0]       index;
      logic                     last;
   } sched_req_type;

   typedef struct {
      logic                     granted;
      logic                     is_write;
      logic [INDEX_W-1:0]       index;
      logic                     drain;
   } grant_type;

   typedef struct {
      logic                     valid;
      logic                     is_write;
      logic                     row_hit;
      logic [INDEX_W-1:0]       index;
      logic [THREAD_IN_W-1:0]   thread;
   } cand_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [1:0]             req_mode = '0;
   logic [CHAN_IN_W-1:0]   req_channel = '0;
   logic [CYCLE_W-1:0]     req_cycle_now = '0;
   logic [QLEN_W-1:0]      req_read_queue_len = '0;
   logic [QLEN_W-1:0]      req_write_queue_len = '0;
   logic                   req_entry_issuable = 1'b0;
   logic                   req_entry_row_hit = 1'b0;
   logic [THREAD_IN_W-1:0] req_entry_thread = '0;
   logic [INDEX_W-1:0]     req_entry_index = '0;
   logic                   req_last_item = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_grant_valid;
   logic                   rsp_grant_is_write;
   logic [INDEX_W-1:0]     rsp_grant_index;
   logic                   rsp_drain_active;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   credit_fair_dram_cmd_scheduler_top dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_mode            (req_mode),
      .req_channel         (req_channel),
      .req_cycle_now       (req_cycle_now),
      .req_read_queue_len  (req_read_queue_len),
      .req_write_queue_len (req_write_queue_len),
      .req_entry_issuable  (req_entry_issuable),
      .req_entry_row_hit   (req_entry_row_hit),
      .req_entry_thread    (req_entry_thread),
      .req_entry_index     (req_entry_index),
      .req_last_item       (req_last_item),
      .rsp_valid           (rsp_valid),
      .rsp_grant_valid     (rsp_grant_valid),
      .rsp_grant_is_write  (rsp_grant_is_write),
      .rsp_grant_index     (rsp_grant_index),
      .rsp_drain_active    (rsp_drain_active),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // scheduler state as the predictor sees it
   logic [QLEN_W-1:0]   cfg_high_wm;
   logic [QLEN_W-1:0]   cfg_low_wm;
   logic [DCNT_W-1:0]   cfg_min_drain;
   logic [CRED_W-1:0]   cfg_credit_cap;
   logic [CRED_W-1:0]   credit_q [NUM_CHANNELS][NUM_THREADS];
   logic [CYCLE_W-1:0]  last_cycle [NUM_CHANNELS];
   logic                drain_on [NUM_CHANNELS];
   logic                drain_empty [NUM_CHANNELS];
   logic [DCNT_W-1:0]   drain_hits [NUM_CHANNELS];
   logic [EFF_W-1:0]    best_eff;
   cand_type            best_cand;
   logic [CHAN_IN_W-1:0] pass_ch;

   sched_req_type       pending_reqs[$];
   grant_type           grants_due[$];
   logic [CYCLE_W-1:0]  chan_cyc [NUM_CHANNELS];
   int                  sender_idle_pct = 0;
   int                  mismatches = 0;
   int                  requests_sent = 0;
   int                  grants_checked = 0;
   int                  settings_used = 0;

   function automatic void log_mismatch(input string what);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("[%0t] mismatch: %s", $realtime, what);
   endfunction

   // advance the predictor by one accepted request
   task automatic schedule_request(input sched_req_type r);
      logic [CYCLE_W-1:0] elapsed;
      logic [CYCLE_W:0]   sum;
      logic [EFF_W-1:0]   eff;
      logic [CHAN_IN_W-1:0] ch;
      grant_type          g;
      ch = r.channel;
      if (r.mode == MODE_BEGIN) begin
         elapsed = r.cycle_now - last_cycle[ch];
         last_cycle[ch] = r.cycle_now;
         for (int t = 0; t < NUM_THREADS; t++) begin
            sum = {1'b0, elapsed} + credit_q[ch][t];
            credit_q[ch][t] = (sum > cfg_credit_cap) ? cfg_credit_cap : sum[CRED_W-1:0];
         end
         if (r.wq_len > cfg_high_wm && !drain_on[ch]) begin
            drain_on[ch] = 1'b1;
            drain_hits[ch] = '0;
         end
         if (r.rq_len == 0 && r.wq_len > 0 && !drain_on[ch]) begin
            drain_on[ch] = 1'b1;
            drain_hits[ch] = '0;
            drain_empty[ch] = 1'b1;
         end
         if (drain_on[ch] && r.wq_len <= cfg_low_wm && !drain_empty[ch])
            drain_on[ch] = 1'b0;
         if (drain_on[ch] && r.rq_len > 0 && drain_empty[ch] &&
             drain_hits[ch] > cfg_min_drain) begin
            drain_on[ch] = 1'b0;
            drain_empty[ch] = 1'b0;
         end
         if (r.wq_len == 0)
            drain_on[ch] = 1'b0;
         best_cand = '{default: '0};
         best_eff = '0;
         pass_ch = ch;
      end else if ((r.mode == MODE_READ || r.mode == MODE_WRITE) && r.issuable) begin
         if (drain_on[pass_ch]) begin
            if (r.mode == MODE_WRITE && (!best_cand.valid || (!best_cand.row_hit && r.row_hit)))
               best_cand = '{1'b1, 1'b1, r.row_hit, r.index, r.thread};
         end else if (r.mode == MODE_READ) begin
            eff = {1'b0, credit_q[pass_ch][r.thread]};
            if (r.row_hit)
               eff = eff + (eff >> 1);
            if (!best_cand.valid || eff > best_eff) begin
               best_eff = eff;
               best_cand = '{1'b1, 1'b0, r.row_hit, r.index, r.thread};
            end
         end
      end
      if (r.last) begin
         g = '{default: '0};
         if (best_cand.valid) begin
            if (best_cand.is_write) begin
               if (best_cand.row_hit && drain_hits[pass_ch] != DCNT_MAX)
                  drain_hits[pass_ch]++;
            end else if (best_cand.row_hit) begin
               credit_q[pass_ch][best_cand.thread] = credit_q[pass_ch][best_cand.thread] >> 1;
            end
            g.granted = 1'b1;
            g.is_write = best_cand.is_write;
            g.index = best_cand.index;
         end
         g.drain = drain_on[pass_ch];
         grants_due.push_back(g);
         best_cand = '{default: '0};
         best_eff = '0;
      end
   endtask

   always @(posedge clock) begin : driver
      logic taken;
      taken = start && (busy === 1'b0);
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (taken) begin
            schedule_request(pending_reqs[0]);
            pending_reqs.delete(0);
            requests_sent++;
         end
         // hold the request until busy drops
         if (start && !taken) begin
         end else if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_mode            <= pending_reqs[0].mode;
            req_channel         <= pending_reqs[0].channel;
            req_cycle_now       <= pending_reqs[0].cycle_now;
            req_read_queue_len  <= pending_reqs[0].rq_len;
            req_write_queue_len <= pending_reqs[0].wq_len;
            req_entry_issuable  <= pending_reqs[0].issuable;
            req_entry_row_hit   <= pending_reqs[0].row_hit;
            req_entry_thread    <= pending_reqs[0].thread;
            req_entry_index     <= pending_reqs[0].index;
            req_last_item       <= pending_reqs[0].last;
            start               <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : monitor
      grant_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (grants_due.size() == 0) begin
            log_mismatch($sformatf("unexpected result granted=%0b write=%0b index=%0d drain=%0b",
                                   rsp_grant_valid, rsp_grant_is_write, rsp_grant_index,
                                   rsp_drain_active));
         end else begin
            want = grants_due.pop_front();
            grants_checked++;
            if (rsp_grant_valid !== want.granted || rsp_grant_is_write !== want.is_write ||
                rsp_grant_index !== want.index || rsp_drain_active !== want.drain)
               log_mismatch($sformatf({"grant %0d: expected granted=%0b write=%0b index=%0d ",
                                       "drain=%0b, got granted=%0b write=%0b index=%0d drain=%0b"},
                                      grants_checked, want.granted, want.is_write, want.index,
                                      want.drain, rsp_grant_valid, rsp_grant_is_write,
                                      rsp_grant_index, rsp_drain_active));
         end
      end
   end

   task automatic queue_request(input mode_type m, input int ch, input logic [CYCLE_W-1:0] cyc,
                                input int rql, input int wql, input bit iss, input bit hit,
                                input int thr, input int idx, input bit last);
      sched_req_type r;
      r.mode      = m;
      r.channel   = ch[CHAN_IN_W-1:0];
      r.cycle_now = cyc;
      r.rq_len    = rql[QLEN_W-1:0];
      r.wq_len    = wql[QLEN_W-1:0];
      r.issuable  = iss;
      r.row_hit   = hit;
      r.thread    = thr[THREAD_IN_W-1:0];
      r.index     = idx[INDEX_W-1:0];
      r.last      = last;
      pending_reqs.push_back(r);
   endtask

   task automatic add_random_passes(input int count);
      int made, n, pick, rql, wql, ch;
      mode_type m;
      made = 0;
      while (made < count) begin
         if ($urandom_range(99) < 80) begin
            ch = $urandom_range(NUM_CHANNELS - 1);
            pick = $urandom_range(99);
            if (pick < 80)
               chan_cyc[ch] += $urandom_range(12);
            else if (pick < 90)
               chan_cyc[ch] += $urandom_range(3000);
            else if (pick < 96)
               chan_cyc[ch] = CYCLE_W'({$urandom, $urandom});
            else
               chan_cyc[ch] -= $urandom_range(1, 50);
            pick = $urandom_range(99);
            rql = (pick < 30) ? 0 : (pick < 35) ? 64 : $urandom_range(1, 64);
            pick = $urandom_range(99);
            wql = (pick < 15) ? 0 : (pick < 25) ? 64 : $urandom_range(0, 64);
            queue_request(MODE_BEGIN, ch, chan_cyc[ch], rql, wql, $urandom_range(1),
                          $urandom_range(1), $urandom_range(127), $urandom_range(63), 1'b0);
            n = $urandom_range(1, 6);
            for (int j = 1; j <= n; j++) begin
               pick = $urandom_range(99);
               if (pick < 5 || (j == n && pick < 10))
                  m = MODE_NONE;
               else
                  m = (pick < 52) ? MODE_READ : MODE_WRITE;
               // mostly a few threads, so halved credits come round again
               queue_request(m, $urandom_range(3), CYCLE_W'({$urandom, $urandom}),
                             $urandom_range(64), $urandom_range(64),
                             $urandom_range(99) < 75, $urandom_range(1),
                             ($urandom_range(99) < 70) ? $urandom_range(7) : $urandom_range(127),
                             $urandom_range(63), j == n);
            end
            made += n + 1;
         end else begin
            queue_request(mode_type'($urandom_range(3)), $urandom_range(3),
                          CYCLE_W'({$urandom, $urandom}), $urandom_range(64),
                          $urandom_range(64), $urandom_range(1), $urandom_range(1),
                          $urandom_range(127), $urandom_range(63), $urandom_range(1));
            made++;
         end
      end
   endtask

   // drain everything outstanding and let any begin pass still sweeping finish
   task automatic wait_idle();
      while (pending_reqs.size() != 0 || grants_due.size() != 0 || start || busy !== 1'b0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input int value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      while (csr_ready !== 1'b1)
         @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_HIGH_WM:    cfg_high_wm    = value[QLEN_W-1:0];
         CSR_LOW_WM:     cfg_low_wm     = value[QLEN_W-1:0];
         CSR_MIN_DRAIN:  cfg_min_drain  = value[DCNT_W-1:0];
         CSR_CREDIT_CAP: cfg_credit_cap = value[CRED_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(input int high_wm, input int low_wm, input int min_drain,
                                input int max_cred);
      csr_write(CSR_HIGH_WM, high_wm);
      csr_write(CSR_LOW_WM, low_wm);
      csr_write(CSR_MIN_DRAIN, min_drain);
      csr_write(CSR_CREDIT_CAP, max_cred);
      settings_used++;
   endtask

   initial begin : stimulus
      cfg_high_wm    = RESET_HIGH_WM;
      cfg_low_wm     = RESET_LOW_WM;
      cfg_min_drain  = RESET_MIN_DRAIN;
      cfg_credit_cap = RESET_CREDIT;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         for (int t = 0; t < NUM_THREADS; t++)
            credit_q[c][t] = RESET_CREDIT;
         last_cycle[c]  = '0;
         drain_on[c]    = 1'b0;
         drain_empty[c] = 1'b0;
         drain_hits[c]  = '0;
         chan_cyc[c]    = '0;
      end
      best_cand = '{default: '0};
      best_eff  = '0;
      pass_ch   = '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      wait_idle();

      apply_setting(40, 20, 1, 1024);
      sender_idle_pct = 7;
      // entries before any begin pass land on channel zero
      queue_request(MODE_READ, 2, '0, 0, 0, 1, 1, 127, 63, 1);
      // watermark drain; first row-hit write wins, read entry closes the pass
      queue_request(MODE_BEGIN, 3, 48'hFFFF_FFFF_FFFF, 64, 64, 0, 0, 0, 0, 0);
      queue_request(MODE_WRITE, 0, '0, 0, 0, 1, 0, 5, 5, 0);
      queue_request(MODE_WRITE, 1, '0, 0, 0, 1, 1, 6, 9, 0);
      queue_request(MODE_WRITE, 2, '0, 0, 0, 1, 1, 7, 10, 0);
      queue_request(MODE_READ, 3, '0, 0, 0, 1, 1, 8, 11, 1);
      // begin pass that closes at once, then an unused mode closing a pass
      queue_request(MODE_BEGIN, 3, '0, 10, 30, 1, 1, 9, 12, 1);
      queue_request(MODE_NONE, 0, '0, 0, 0, 1, 1, 10, 13, 1);
      // empty read queue drain, held until enough row-hit writes have gone
      queue_request(MODE_BEGIN, 1, 48'd100, 0, 1, 0, 0, 0, 0, 0);
      queue_request(MODE_WRITE, 1, '0, 0, 0, 0, 1, 11, 1, 0);
      queue_request(MODE_WRITE, 1, '0, 0, 0, 1, 1, 12, 2, 1);
      queue_request(MODE_BEGIN, 1, 48'd200, 5, 1, 0, 0, 0, 0, 0);
      queue_request(MODE_WRITE, 1, '0, 0, 0, 1, 1, 13, 3, 1);
      // cycle going backwards saturates every credit; ties keep the earlier entry
      queue_request(MODE_BEGIN, 1, 48'd150, 5, 1, 0, 0, 0, 0, 0);
      queue_request(MODE_READ, 0, '0, 0, 0, 1, 0, 0, 0, 0);
      queue_request(MODE_READ, 0, '0, 0, 0, 1, 1, 127, 1, 0);
      queue_request(MODE_READ, 0, '0, 0, 0, 1, 1, 1, 2, 0);
      queue_request(MODE_WRITE, 0, '0, 0, 0, 1, 1, 2, 7, 1);
      // halved credit loses to a full one
      queue_request(MODE_BEGIN, 0, '0, 0, 0, 0, 0, 0, 0, 0);
      queue_request(MODE_READ, 0, '0, 0, 0, 1, 0, 127, 4, 0);
      queue_request(MODE_READ, 0, '0, 0, 0, 1, 0, 126, 5, 0);
      queue_request(MODE_READ, 0, '0, 0, 0, 0, 1, 127, 63, 1);
      queue_request(MODE_BEGIN, 2, 48'h8000_0000_0000, 64, 0, 1, 1, 3, 3, 1);
      queue_request(MODE_READ, 1, '0, 0, 0, 1, 0, 64, 32, 1);
      add_random_passes(110);
      wait_idle();

      apply_setting(64, 0, 255, 1);
      sender_idle_pct = 65;
      add_random_passes(110);
      wait_idle();

      apply_setting(0, 64, 0, 1024);
      sender_idle_pct = 0;
      add_random_passes(110);
      wait_idle();

      apply_setting($urandom_range(64), $urandom_range(64), $urandom_range(8),
                    $urandom_range(1, 300));
      add_random_passes(100);
      wait_idle();

      $display("Ran %0d scheduler requests over %0d register settings; %0d grants checked.",
               requests_sent, settings_used, grants_checked);
      $display("Mismatches: %0d, grants still outstanding: %0d", mismatches, grants_due.size());
      if (mismatches == 0 && grants_due.size() == 0)
         $display("PASS credit_fair_dram_cmd_scheduler_top");
      else
         $display("FAIL credit_fair_dram_cmd_scheduler_top");
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("Timed out with %0d requests pending and %0d grants outstanding",
               pending_reqs.size(), grants_due.size());
      $display("FAIL credit_fair_dram_cmd_scheduler_top");
      $finish;
   end

endmodule

// ===== credit_fair_dram_cmd_scheduler_top.f =====
+incdir+rtl/core
rtl/core/cfdcs_pkg.sv
rtl/core/cfdcs_ram.sv
rtl/core/cfdcs_credit_alu.sv
rtl/core/cfdcs_drain.sv
rtl/core/credit_fair_dram_cmd_scheduler_top.sv
rtl/core/cfdcs_checker.sv
tb/tb.sv
